// File: hw/rtl/list_pkg.sv
// shared types and constants for the labelled interval segment table
`timescale 1ns / 1ps
package list_pkg;

  localparam int MAX_SEG = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;
  localparam int POS_W   = 32;
  localparam int LAB_W   = 31;
  localparam int ANC_W   = 18;

  // ancestry = label / 10000 as (label * ANC_MUL) >> ANC_SHIFT, exact for 31-bit labels
  localparam int ANC_SHIFT = 44;
  localparam logic [31:0] ANC_MUL = 32'd1759218605;

  typedef enum logic [2:0] {
    FN_CLEAR   = 3'd0,
    FN_APPEND  = 3'd1,
    FN_LOCATE  = 3'd2,
    FN_READ    = 3'd3,
    FN_MERGE   = 3'd4,
    FN_EXTRACT = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_FULL     = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_EMPTY    = 3'd3,
    ERR_RANGE    = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_EMIT,
    ST_MERGE,
    ST_AP_Q,
    ST_AP_WR
  } state_t;

  // one table entry: ancestry, label and end position
  typedef struct packed {
    logic [ANC_W-1:0] anc;
    logic [LAB_W-1:0] lab;
    logic [POS_W-1:0] pend;
  } entry_t;

endpackage

// File: hw/rtl/labelled_interval_segment_table.sv
// labelled interval segment table: sequencer, entry memory and output register
// clear and error results are registered from the idle state; append passes through ST_AP_Q and ST_AP_WR;
// read streams entries out; locate and extract scan, evaluate, then emit, one piece per cycle; merge walks every entry
// one operation at a time, busy stays high while the table walk runs
// the walk over the entry memory makes one registered read per cycle
// reset (synchronous, rst_n low) empties the table; results cannot be stalled
`timescale 1ns / 1ps
module labelled_interval_segment_table import list_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       in_func,
  input  logic [POS_W-1:0] in_pos_a,
  input  logic [POS_W-1:0] in_pos_b,
  input  logic [LAB_W-1:0] in_label,
  input  logic [IDX_W-1:0] in_index,
  output logic             out_valid,
  output logic [POS_W-1:0] out_seg_start,
  output logic [POS_W-1:0] out_seg_end,
  output logic [LAB_W-1:0] out_seg_label,
  output logic [IDX_W-1:0] out_seg_index,
  output logic [CNT_W-1:0] out_seg_count,
  output logic             out_last,
  output logic [2:0]       out_error
);

  state_t state_r, state_nxt;

  // table state
  entry_t           mem [MAX_SEG];
  entry_t           rd_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] first_start_r, first_start_nxt;
  logic [POS_W-1:0] last_end_r, last_end_nxt;

  // operation registers
  func_t            func_r, func_nxt;
  logic [POS_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [LAB_W-1:0] lab_r, lab_nxt;
  logic [ANC_W-1:0] q_r, q_nxt;

  // walk control
  logic [CNT_W-1:0] ra_r, ra_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] da_r, da_nxt;
  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic             found_r, found_nxt, eq_r, eq_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic             clip_r, clip_nxt;
  logic [POS_W-1:0] prev_end_r, prev_end_nxt;
  logic [IDX_W-1:0] w_r, w_nxt;
  logic [ANC_W-1:0] wq_r, wq_nxt;
  logic [LAB_W-1:0] wlab_r, wlab_nxt;

  // memory write port
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  // output register
  logic             ov_r, ov_nxt;
  logic [POS_W-1:0] os_r, os_nxt, oe_r, oe_nxt;
  logic [LAB_W-1:0] ol_r, ol_nxt;
  logic [IDX_W-1:0] oi_r, oi_nxt;
  logic [CNT_W-1:0] oc_r, oc_nxt;
  logic             olast_r, olast_nxt;
  err_t             oerr_r, oerr_nxt;

  // helpers
  logic [CNT_W-1:0] cnt_m1;
  logic             accept;
  logic             data_done;
  logic [POS_W:0]   ap_sum;
  logic [POS_W-1:0] ap_len;
  logic [62:0]      prod;
  logic [CNT_W-1:0] si, ei;
  logic [IDX_W-1:0] rd_base;
  logic [IDX_W-1:0] first_rd;

  assign cnt_m1    = count_r - CNT_W'(1);
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign data_done = dv_r && ({1'b0, da_r} == cnt_m1);
  assign ap_len    = in_pos_b - in_pos_a;
  assign ap_sum    = {1'b0, last_end_r} + {1'b0, ap_len};
  assign prod      = {32'd0, lab_r} * {31'd0, ANC_MUL};
  assign si        = cnt_a_r + CNT_W'(eq_r);
  assign ei        = cnt_b_r;
  // unclipped reads start one entry early to pick up the segment start
  assign rd_base   = (state_r == ST_IDLE) ? in_index : cnt_a_r[IDX_W-1:0];
  assign first_rd  = (rd_base != '0) ? rd_base - IDX_W'(1) : rd_base;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_func)
            FN_APPEND: begin
              if (count_r < CNT_W'(MAX_SEG) && in_pos_b >= in_pos_a &&
                  (count_r == '0 || !ap_sum[POS_W])) begin
                state_nxt = ST_AP_Q;
              end
            end
            FN_LOCATE: if (count_r != '0) state_nxt = ST_SCAN;
            FN_READ: begin
              if (count_r != '0 && {1'b0, in_index} < count_r) state_nxt = ST_EMIT;
            end
            FN_MERGE: if (count_r != '0) state_nxt = ST_MERGE;
            FN_EXTRACT: begin
              if (count_r != '0 && in_pos_a < in_pos_b && in_pos_a >= first_start_r &&
                  in_pos_b <= last_end_r) begin
                state_nxt = ST_SCAN;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN:  if (data_done) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (func_r == FN_LOCATE) begin
          state_nxt = ST_EMIT;
        end else if (si >= count_r || ei >= count_r || si > ei) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT:  if (dv_r && da_r == hi_r) state_nxt = ST_IDLE;
      ST_MERGE: if (data_done) state_nxt = ST_IDLE;
      ST_AP_Q:  state_nxt = ST_AP_WR;
      ST_AP_WR: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt       = count_r;
    first_start_nxt = first_start_r;
    last_end_nxt    = last_end_r;
    func_nxt        = func_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    lab_nxt         = lab_r;
    q_nxt           = q_r;
    ra_nxt          = ra_r;
    dv_nxt          = 1'b0;
    da_nxt          = ra_r[IDX_W-1:0];
    cnt_a_nxt       = cnt_a_r;
    cnt_b_nxt       = cnt_b_r;
    found_nxt       = found_r;
    eq_nxt          = eq_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    clip_nxt        = clip_r;
    prev_end_nxt    = prev_end_r;
    w_nxt           = w_r;
    wq_nxt          = wq_r;
    wlab_nxt        = wlab_r;
    we              = 1'b0;
    wa              = w_r;
    wd              = '{anc: wq_r, lab: wlab_r, pend: rd_r.pend};
    ov_nxt          = 1'b0;
    os_nxt          = '0;
    oe_nxt          = '0;
    ol_nxt          = '0;
    oi_nxt          = '0;
    oc_nxt          = count_r;
    olast_nxt       = 1'b1;
    oerr_nxt        = ERR_OK;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = func_t'(in_func);
          a_nxt     = in_pos_a;
          b_nxt     = in_pos_b;
          lab_nxt   = in_label;
          ra_nxt    = '0;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          found_nxt = 1'b0;
          eq_nxt    = 1'b0;
          w_nxt     = '0;
          ov_nxt    = 1'b1;
          unique case (in_func)
            FN_CLEAR: begin
              count_nxt       = '0;
              first_start_nxt = '0;
              oc_nxt          = '0;
            end
            FN_APPEND: begin
              if (count_r >= CNT_W'(MAX_SEG)) begin
                oerr_nxt = ERR_FULL;
              end else if (in_pos_b < in_pos_a) begin
                oerr_nxt = ERR_RANGE;
              end else if (count_r == '0) begin
                ov_nxt          = 1'b0;
                first_start_nxt = in_pos_a;
              end else if (ap_sum[POS_W]) begin
                oerr_nxt = ERR_OVERFLOW;
              end else begin
                ov_nxt = 1'b0;
                a_nxt  = last_end_r;
                b_nxt  = ap_sum[POS_W-1:0];
              end
            end
            FN_LOCATE, FN_MERGE: begin
              if (count_r == '0) oerr_nxt = ERR_EMPTY;
              else ov_nxt = 1'b0;
            end
            FN_READ: begin
              if (count_r == '0) begin
                oerr_nxt = ERR_EMPTY;
              end else if ({1'b0, in_index} >= count_r) begin
                oerr_nxt = ERR_RANGE;
              end else begin
                ov_nxt   = 1'b0;
                lo_nxt   = in_index;
                hi_nxt   = in_index;
                clip_nxt = 1'b0;
                ra_nxt   = {1'b0, first_rd};
              end
            end
            FN_EXTRACT: begin
              if (count_r == '0) begin
                oerr_nxt = ERR_EMPTY;
              end else if (!(in_pos_a < in_pos_b && in_pos_a >= first_start_r &&
                             in_pos_b <= last_end_r)) begin
                oerr_nxt = ERR_RANGE;
              end else begin
                ov_nxt = 1'b0;
              end
            end
            default: oerr_nxt = ERR_RANGE;
          endcase
        end
      end

      // walk all ends, counting interior breaks below both positions
      ST_SCAN: begin
        if (ra_r < count_r) begin
          ra_nxt = ra_r + CNT_W'(1);
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if ({1'b0, da_r} < cnt_m1) begin
            if (rd_r.pend < a_r) cnt_a_nxt = cnt_a_r + CNT_W'(1);
            if (rd_r.pend < b_r) cnt_b_nxt = cnt_b_r + CNT_W'(1);
          end
          if (!found_r && rd_r.pend >= a_r) begin
            found_nxt = 1'b1;
            eq_nxt    = (rd_r.pend == a_r);
          end
        end
      end

      // choose the run of segments to read back, or report a range error
      ST_EVAL: begin
        if (func_r == FN_LOCATE) begin
          lo_nxt   = cnt_a_r[IDX_W-1:0];
          hi_nxt   = cnt_a_r[IDX_W-1:0];
          clip_nxt = 1'b0;
          ra_nxt   = {1'b0, first_rd};
        end else if (si >= count_r || ei >= count_r || si > ei) begin
          ov_nxt   = 1'b1;
          oerr_nxt = ERR_RANGE;
        end else begin
          lo_nxt   = si[IDX_W-1:0];
          hi_nxt   = ei[IDX_W-1:0];
          clip_nxt = 1'b1;
          ra_nxt   = si;
        end
      end

      // stream entries lo..hi out, one piece per cycle
      ST_EMIT: begin
        if (ra_r <= {1'b0, hi_r}) begin
          ra_nxt = ra_r + CNT_W'(1);
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          prev_end_nxt = rd_r.pend;
          if (da_r >= lo_r) begin
            ov_nxt    = 1'b1;
            olast_nxt = (da_r == hi_r);
            ol_nxt    = rd_r.lab;
            oi_nxt    = da_r;
            if (da_r == lo_r) begin
              if (clip_r)          os_nxt = a_r;
              else if (lo_r == '0) os_nxt = first_start_r;
              else                 os_nxt = prev_end_r;
            end else begin
              os_nxt = prev_end_r;
            end
            oe_nxt = (da_r == hi_r && clip_r) ? b_r : rd_r.pend;
          end
        end
      end

      // fuse neighbours with the same ancestry, compacting in place
      ST_MERGE: begin
        if (ra_r < count_r) begin
          ra_nxt = ra_r + CNT_W'(1);
          dv_nxt = 1'b1;
        end
        if (dv_r) begin
          if (da_r == '0) begin
            wq_nxt   = rd_r.anc;
            wlab_nxt = rd_r.lab;
            w_nxt    = '0;
          end else if (rd_r.anc == wq_r) begin
            we = 1'b1;
          end else begin
            we       = 1'b1;
            wa       = w_r + IDX_W'(1);
            wd       = rd_r;
            w_nxt    = w_r + IDX_W'(1);
            wq_nxt   = rd_r.anc;
            wlab_nxt = rd_r.lab;
          end
          if (data_done) begin
            count_nxt = {1'b0, w_nxt} + CNT_W'(1);
            ov_nxt    = 1'b1;
            oc_nxt    = {1'b0, w_nxt} + CNT_W'(1);
          end
        end
      end

      ST_AP_Q: q_nxt = prod[ANC_SHIFT+ANC_W-1:ANC_SHIFT];

      // store the new segment and report it
      ST_AP_WR: begin
        we           = 1'b1;
        wa           = count_r[IDX_W-1:0];
        wd           = '{anc: q_r, lab: lab_r, pend: b_r};
        count_nxt    = count_r + CNT_W'(1);
        last_end_nxt = b_r;
        ov_nxt       = 1'b1;
        os_nxt       = a_r;
        oe_nxt       = b_r;
        ol_nxt       = lab_r;
        oi_nxt       = count_r[IDX_W-1:0];
        oc_nxt       = count_r + CNT_W'(1);
      end

      default: ;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra_r[IDX_W-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      first_start_r <= '0;
      dv_r          <= 1'b0;
      ra_r          <= '0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      first_start_r <= first_start_nxt;
      dv_r          <= dv_nxt;
      ra_r          <= ra_nxt;
      ov_r          <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_end_r <= last_end_nxt;
    func_r     <= func_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    lab_r      <= lab_nxt;
    q_r        <= q_nxt;
    da_r       <= da_nxt;
    cnt_a_r    <= cnt_a_nxt;
    cnt_b_r    <= cnt_b_nxt;
    found_r    <= found_nxt;
    eq_r       <= eq_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    clip_r     <= clip_nxt;
    prev_end_r <= prev_end_nxt;
    w_r        <= w_nxt;
    wq_r       <= wq_nxt;
    wlab_r     <= wlab_nxt;
    os_r       <= os_nxt;
    oe_r       <= oe_nxt;
    ol_r       <= ol_nxt;
    oi_r       <= oi_nxt;
    oc_r       <= oc_nxt;
    olast_r    <= olast_nxt;
    oerr_r     <= oerr_nxt;
  end

  // result ports
  assign out_valid     = ov_r;
  assign out_seg_start = os_r;
  assign out_seg_end   = oe_r;
  assign out_seg_label = ol_r;
  assign out_seg_index = oi_r;
  assign out_seg_count = oc_r;
  assign out_last      = olast_r;
  assign out_error     = oerr_r;

endmodule
